// ===== hw/rtl/mxm_pkg.sv =====
package mxm_pkg;

	localparam int DATA_W  = 32;
	localparam int VEC_N   = 4;
	localparam int IDX_W   = 2;
	localparam int PROD_W  = 2 * DATA_W;
	// four products added exactly need two growth bits
	localparam int SUM_W   = PROD_W + 2;
	localparam int TDATA_W = 136;
	localparam int PAD_W   = TDATA_W - IDX_W - VEC_N * DATA_W;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MUL  = 1'b1
	} cmd_t;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef elem_t [VEC_N-1:0] vec_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef sum_t [VEC_N-1:0] sum_vec_t;

	// stage enables shared by all lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} lane_ctl_t;

endpackage

// ===== hw/rtl/mxm_lane.sv =====
module mxm_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  mxm_pkg::lane_ctl_t ctl,
	input  mxm_pkg::vec_t      row,
	input  mxm_pkg::vec_t      col,
	output mxm_pkg::sum_t      sum_s2
);
	import mxm_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [VEC_N];
	logic signed [PROD_W-1:0] shifted [VEC_N];
	sum_t                     sum_d;

	// one 32x32 multiplier per element
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int e = 0; e < VEC_N; e++) begin
				prod_s1[e] <= PROD_W'($signed(row[e])) * PROD_W'($signed(col[e]));
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int e = 0; e < VEC_N; e++) begin
			shifted[e] = prod_s1[e] >>> FRAC_BITS;
			sum_d      = sum_d + SUM_W'(shifted[e]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sum_s2 <= sum_d;
		end
	end

endmodule

// ===== hw/rtl/mxm_merge.sv =====
module mxm_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	input  logic [mxm_pkg::IDX_W-1:0]     idx_s2,
	input  mxm_pkg::sum_vec_t             sums_s2,
	input  logic                          out_ready,
	output logic                          take,
	output logic                          out_valid_q,
	output logic [mxm_pkg::IDX_W-1:0]     out_idx_q,
	output mxm_pkg::vec_t                 out_vals_q,
	output logic                          out_ovf_q
);
	import mxm_pkg::*;

	vec_t sat_vals;
	logic ovf_d;
	logic [VEC_N-1:0] lane_ovf;

	// saturate each lane to 32 bits, any clipped lane flags overflow
	always_comb begin
		for (int r = 0; r < VEC_N; r++) begin
			lane_ovf[r] = !((&sums_s2[r][SUM_W-1:DATA_W-1]) ||
			               !(|sums_s2[r][SUM_W-1:DATA_W-1]));
			if (!lane_ovf[r]) begin
				sat_vals[r] = sums_s2[r][DATA_W-1:0];
			end else if (sums_s2[r][SUM_W-1]) begin
				sat_vals[r] = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				sat_vals[r] = {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
		ovf_d = |lane_ovf;
	end

	assign take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s2) begin
			out_idx_q  <= idx_s2;
			out_vals_q <= sat_vals;
			out_ovf_q  <= ovf_d;
		end
	end

endmodule

// ===== hw/rtl/matrix4x4_multiply.sv =====
// 4x4 fixed-point matrix multiply, product = L x R, values signed Q16.16
// input stream (s_axis): one transfer per item, tuser selects the command
//   load transfer: writes row tdata.index of L, returns nothing
//   multiply transfer: carries one column of R, returns that product column
// output stream (m_axis): one transfer per multiply, column tag in tdata,
//   saturation flag in tuser
// path: a multiply is accepted into the product register, then passes the
//   shift and add stage register, then the saturate/output register that
//   presents it on m_axis
// throughput: one item per cycle unless stalled, loads and multiplies mixed
//   freely; a load is seen by a multiply accepted in the very next cycle
// sixteen 32x32 multipliers, one per element of L, set the one-per-cycle rate
// stall: when m_axis_tready is low the output register holds; bubbles in the
//   pipeline still fill, then s_axis_tready drops until the result is taken
// reset: L clears to zero, pipeline and output valids clear; no clearing pass
module matrix4x4_multiply #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// index, in_value_0, in_value_1, in_value_2, in_value_3, zero pad
	input  logic [mxm_pkg::TDATA_W-1:0]     s_axis_tdata,
	// command
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// column_index, out_value_0, out_value_1, out_value_2, out_value_3, zero pad
	output logic [mxm_pkg::TDATA_W-1:0]     m_axis_tdata,
	// overflow
	output logic                            m_axis_tuser
);
	import mxm_pkg::*;

	// unpacked input fields
	cmd_t             cmd;
	logic [IDX_W-1:0] idx;
	vec_t             in_vec;

	// stored left matrix, one row per lane
	vec_t             left_q [VEC_N];

	// pipeline control
	logic             accept;
	logic             valid_s1;
	logic             valid_s2;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] idx_s2;
	lane_ctl_t        ctl;
	logic             out_take;

	// lane outputs and merged result
	sum_vec_t         sums_s2;
	logic [IDX_W-1:0] out_idx_q;
	vec_t             out_vals_q;
	logic             out_ovf_q;

	assign cmd = cmd_t'(s_axis_tuser);
	assign idx = s_axis_tdata[IDX_W-1:0];

	always_comb begin
		for (int e = 0; e < VEC_N; e++) begin
			in_vec[e] = s_axis_tdata[IDX_W + e*DATA_W +: DATA_W];
		end
	end

	// each stage moves when the one after it is empty or moving
	assign ctl.en_s2     = !valid_s2 || out_take;
	assign ctl.en_s1     = !valid_s1 || ctl.en_s2;
	assign s_axis_tready = ctl.en_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// row write on a load transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < VEC_N; r++) begin
				left_q[r] <= '0;
			end
		end else if (accept && cmd == CMD_LOAD) begin
			left_q[idx] <= in_vec;
		end
	end

	// valids follow multiply transfers only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				valid_s1 <= accept && cmd == CMD_MUL;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// column tag rides alongside the lanes
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			idx_s1 <= idx;
		end
		if (ctl.en_s2) begin
			idx_s2 <= idx_s1;
		end
	end

	// one lane per row of L, all fed the same incoming column
	for (genvar r = 0; r < VEC_N; r++) begin : g_lane
		mxm_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.row    (left_q[r]),
			.col    (in_vec),
			.sum_s2 (sums_s2[r])
		);
	end

	// saturation, overflow merge and output register
	mxm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.idx_s2      (idx_s2),
		.sums_s2     (sums_s2),
		.out_ready   (m_axis_tready),
		.take        (out_take),
		.out_valid_q (m_axis_tvalid),
		.out_idx_q   (out_idx_q),
		.out_vals_q  (out_vals_q),
		.out_ovf_q   (out_ovf_q)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, out_vals_q, out_idx_q};
	assign m_axis_tuser = out_ovf_q;

endmodule
